@@ design/stq_pkg.sv @@
// Package for the sorted expiry timer queue.
// Holds codes, widths and the chain struct shared by the cells and the top level.
// No dependencies.
package stq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 10;
    localparam int DL_W            = 32;
    localparam int MAX_REPORTS     = 16;
    localparam int RPT_W           = $clog2(MAX_REPORTS);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_DUPLICATE = 2'd3
    } t_status;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_EXPIRY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_POP    = 2'd3
    } t_cell_op;

    // Flags rippled from cell to cell: after = slot is empty or strictly later than the key,
    // match = key handle seen at or before this slot.
    typedef struct packed {
        logic after;
        logic match;
    } t_chain;

endpackage

@@ design/stq_if.sv @@
// Handshake interfaces for the command and result channels.
// Depends on stq_pkg for widths.
interface stq_in_if import stq_pkg::*; #(parameter int HANDLE_BITS = HANDLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [1:0]             mode;
    logic [HANDLE_BITS-1:0] handle;
    logic [DL_W-1:0]        deadline;
    logic [DL_W-1:0]        now_time;

    modport source (output valid, mode, handle, deadline, now_time, input ready);
    modport sink   (input valid, mode, handle, deadline, now_time, output ready);
endinterface

interface stq_out_if import stq_pkg::*; #(parameter int HANDLE_BITS = HANDLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [HANDLE_BITS-1:0] expired_handle;
    logic [1:0]             status;
    logic                   last;

    modport source (output valid, kind, expired_handle, status, last, input ready);
    modport sink   (input valid, kind, expired_handle, status, last, output ready);
endinterface

@@ design/sorted_expiry_timer_queue_unit.sv @@
// Channel  Dir  Payload                                   Accepted when
// i_cmd    in   mode, handle, deadline, now_time          valid && ready
// o_res    out  kind, expired_handle, status, last        valid && ready
//
// Add and delete finish in ST_EXEC; adjust also passes ST_INS (remove, then re-insert through the cell chain).
// A tick reports its expired handles one by one in ST_DRAIN, up to MAX_REPORTS per tick.
// i_cmd.ready is high only between operations; a full result register holds the chain.
// Synchronous active-low reset empties the chain; slot payload is not cleared.
// Stalls on o_res delay the chain step and hold the result unchanged.
// Top level: control sequencer, result register and the row of stq_cell slots.
module sorted_expiry_timer_queue_unit import stq_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stq_in_if.sink     i_cmd,
    stq_out_if.source  o_res
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_INS   = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_mode                  r_mode;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [DL_W-1:0]        r_deadline;
    logic [DL_W-1:0]        r_now;
    logic [RPT_W-1:0]       r_rpt, n_rpt;

    logic                   r_out_valid, n_out_valid;
    t_kind                  r_kind, n_kind;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;
    t_status                r_status, n_status;
    logic                   r_last, n_last;

    t_cell_op               w_op;
    t_chain                 w_chain [DEPTH+1];
    logic                   w_valid [DEPTH];
    logic [DL_W-1:0]        w_dl    [DEPTH];
    logic [HANDLE_BITS-1:0] w_hdl   [DEPTH];

    logic w_out_free;
    logic w_found;
    logic w_full;
    logic w_head_exp;
    logic w_next_exp;
    logic w_accept;

    assign w_chain[0]  = '0;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_found     = w_chain[DEPTH].match;
    assign w_full      = w_valid[DEPTH-1];
    assign w_head_exp  = w_valid[0] && (w_dl[0] <= r_now);
    assign w_next_exp  = w_valid[1] && (w_dl[1] <= r_now);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                   w_lv, w_rv;
            logic [DL_W-1:0]        w_ld, w_rd;
            logic [HANDLE_BITS-1:0] w_lh, w_rh;
            if (gi == 0) begin : g_left_edge
                assign w_lv = 1'b0;
                assign w_ld = '0;
                assign w_lh = '0;
            end else begin : g_left
                assign w_lv = w_valid[gi-1];
                assign w_ld = w_dl[gi-1];
                assign w_lh = w_hdl[gi-1];
            end
            if (gi == DEPTH-1) begin : g_right_edge
                assign w_rv = 1'b0;
                assign w_rd = '0;
                assign w_rh = '0;
            end else begin : g_right
                assign w_rv = w_valid[gi+1];
                assign w_rd = w_dl[gi+1];
                assign w_rh = w_hdl[gi+1];
            end
            stq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
                .i_clk            (i_clk),
                .i_rst_n          (i_rst_n),
                .i_op             (w_op),
                .i_key_deadline   (r_deadline),
                .i_key_handle     (r_handle),
                .i_chain          (w_chain[gi]),
                .o_chain          (w_chain[gi+1]),
                .i_left_valid     (w_lv),
                .i_left_deadline  (w_ld),
                .i_left_handle    (w_lh),
                .i_right_valid    (w_rv),
                .i_right_deadline (w_rd),
                .i_right_handle   (w_rh),
                .o_valid          (w_valid[gi]),
                .o_deadline       (w_dl[gi]),
                .o_handle         (w_hdl[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_rpt        = r_rpt;
        w_op         = OP_HOLD;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_kind       = r_kind;
        n_out_handle = r_out_handle;
        n_status     = r_status;
        n_last       = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_mode == MODE_TICK) begin
                    n_rpt   = '0;
                    n_state = w_head_exp ? ST_DRAIN : ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_kind       = KIND_STATUS;
                    n_out_handle = '0;
                    n_last       = 1'b1;
                    n_state      = ST_IDLE;
                    if (r_mode == MODE_ADD) begin
                        if (w_found) begin
                            n_status = STAT_DUPLICATE;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status = STAT_OK;
                            w_op     = OP_INSERT;
                        end
                    end else if (!w_found) begin
                        n_status = STAT_NOT_FOUND;
                    end else begin
                        n_status = STAT_OK;
                        w_op     = OP_REMOVE;
                        if (r_mode == MODE_ADJUST) begin
                            n_state = ST_INS;
                        end
                    end
                end
            end
            ST_INS: begin
                w_op    = OP_INSERT;
                n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    w_op         = OP_POP;
                    n_out_valid  = 1'b1;
                    n_kind       = KIND_EXPIRY;
                    n_out_handle = w_hdl[0];
                    n_status     = STAT_OK;
                    n_last       = !w_next_exp || (r_rpt == RPT_W'(MAX_REPORTS - 1));
                    n_rpt        = r_rpt + 1'b1;
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rpt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rpt       <= n_rpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= t_mode'(i_cmd.mode);
            r_handle   <= i_cmd.handle;
            r_deadline <= i_cmd.deadline;
            r_now      <= i_cmd.now_time;
        end
        r_kind       <= n_kind;
        r_out_handle <= n_out_handle;
        r_status     <= n_status;
        r_last       <= n_last;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_kind;
    assign o_res.expired_handle = r_out_handle;
    assign o_res.status         = r_status;
    assign o_res.last           = r_last;

endmodule

@@ design/stq_cell.sv @@
// One slot of the timer chain: valid bit, deadline and handle.
// Shifts toward its neighbors on insert, remove and pop. Depends on stq_pkg.
module stq_cell import stq_pkg::*; #(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_op               i_op,
    input  logic [DL_W-1:0]        i_key_deadline,
    input  logic [HANDLE_BITS-1:0] i_key_handle,
    input  t_chain                 i_chain,
    output t_chain                 o_chain,
    input  logic                   i_left_valid,
    input  logic [DL_W-1:0]        i_left_deadline,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    input  logic                   i_right_valid,
    input  logic [DL_W-1:0]        i_right_deadline,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    output logic                   o_valid,
    output logic [DL_W-1:0]        o_deadline,
    output logic [HANDLE_BITS-1:0] o_handle
);

    logic                   r_valid;
    logic [DL_W-1:0]        r_deadline;
    logic [HANDLE_BITS-1:0] r_handle;
    logic                   n_valid;
    logic [DL_W-1:0]        n_deadline;
    logic [HANDLE_BITS-1:0] n_handle;

    always_comb begin
        o_chain.after = !r_valid || (r_deadline > i_key_deadline);
        o_chain.match = i_chain.match || (r_valid && (r_handle == i_key_handle));
    end

    always_comb begin
        n_valid    = r_valid;
        n_deadline = r_deadline;
        n_handle   = r_handle;
        unique case (i_op)
            OP_INSERT: begin
                if (o_chain.after) begin
                    if (i_chain.after) begin
                        n_valid    = i_left_valid;
                        n_deadline = i_left_deadline;
                        n_handle   = i_left_handle;
                    end else begin
                        n_valid    = 1'b1;
                        n_deadline = i_key_deadline;
                        n_handle   = i_key_handle;
                    end
                end
            end
            OP_REMOVE: begin
                if (o_chain.match) begin
                    n_valid    = i_right_valid;
                    n_deadline = i_right_deadline;
                    n_handle   = i_right_handle;
                end
            end
            OP_POP: begin
                n_valid    = i_right_valid;
                n_deadline = i_right_deadline;
                n_handle   = i_right_handle;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_deadline;
        r_handle   <= n_handle;
    end

    assign o_valid    = r_valid;
    assign o_deadline = r_deadline;
    assign o_handle   = r_handle;

endmodule

@@ design/stq_chk.sv @@
// Port-level checks for the sorted expiry timer queue, bound to the top level.
// Depends on stq_pkg for codes.
module stq_chk import stq_pkg::*; #(
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cmd_valid,
    input logic                   i_cmd_ready,
    input logic                   i_res_valid,
    input logic                   i_res_ready,
    input logic                   i_res_kind,
    input logic [HANDLE_BITS-1:0] i_res_handle,
    input logic [1:0]             i_res_status,
    input logic                   i_res_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_handle)
            && $stable(i_res_kind) && $stable(i_res_status) && $stable(i_res_last))
        else $error("stalled result changed");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == KIND_STATUS) |-> i_res_last && (i_res_handle == '0))
        else $error("status result without last or with a handle");

    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_kind == KIND_EXPIRY) |-> (i_res_status == STAT_OK))
        else $error("expiry report with nonzero status");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("item accepted while previous one in progress");

endmodule

bind sorted_expiry_timer_queue_unit stq_chk #(.HANDLE_BITS(HANDLE_BITS)) u_stq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_handle (o_res.expired_handle),
    .i_res_status (o_res.status),
    .i_res_last   (o_res.last)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_expiry_timer_queue_unit: directed, full-queue and random traffic.
// A local sorted timer list predicts every status and expiry item; results are checked in order.
// Depends on stq_pkg, stq_in_if and stq_out_if from the design folder.
module testbench;
    import stq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int HB          = HANDLE_BITS_DEF;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SETTLE_CYC  = 40;

    typedef struct {
        t_kind          kind;
        logic [HB-1:0]  handle;
        t_status        status;
        logic           last;
    } t_timer_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stq_in_if  #(.HANDLE_BITS(HB)) cmd_if ();
    stq_out_if #(.HANDLE_BITS(HB)) res_if ();

    sorted_expiry_timer_queue_unit #(.DEPTH(DEPTH), .HANDLE_BITS(HB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_timer_reply  replies_due[$];
    logic [31:0]   tq_deadline[DEPTH];
    logic [HB-1:0] tq_handle[DEPTH];
    int            tq_count;
    int            fail_count;
    int            idle_cycles;
    int            sink_wait;
    bit            idle_on;

    function automatic int draw_gap();
        if (!idle_on) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic int slot_of(logic [HB-1:0] h);
        for (int i = 0; i < tq_count; i++)
            if (tq_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < tq_count; i++) begin
            tq_deadline[i] = tq_deadline[i + 1];
            tq_handle[i]   = tq_handle[i + 1];
        end
        tq_count--;
    endfunction

    function automatic void place_sorted(logic [HB-1:0] h, logic [31:0] dl);
        int pos;
        pos = 0;
        while (pos < tq_count && tq_deadline[pos] <= dl) pos++;
        for (int i = tq_count; i > pos; i--) begin
            tq_deadline[i] = tq_deadline[i - 1];
            tq_handle[i]   = tq_handle[i - 1];
        end
        tq_deadline[pos] = dl;
        tq_handle[pos]   = h;
        tq_count++;
    endfunction

    function automatic void expect_reply(t_kind k, logic [HB-1:0] h, t_status s, logic last);
        t_timer_reply r;
        r.kind   = k;
        r.handle = h;
        r.status = s;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    function automatic void timer_list_apply(t_mode m, logic [HB-1:0] h, logic [31:0] dl,
                                             logic [31:0] now);
        int pos;
        int n;
        if (m == MODE_TICK) begin
            n = 0;
            while (tq_count > 0 && n < MAX_REPORTS && tq_deadline[0] <= now) begin
                expect_reply(KIND_EXPIRY, tq_handle[0], STAT_OK, 1'b0);
                drop_slot(0);
                n++;
            end
            if (n > 0) replies_due[replies_due.size() - 1].last = 1'b1;
            return;
        end
        pos = slot_of(h);
        if (m == MODE_ADD) begin
            if (pos >= 0) begin
                expect_reply(KIND_STATUS, '0, STAT_DUPLICATE, 1'b1);
            end else if (tq_count >= DEPTH) begin
                expect_reply(KIND_STATUS, '0, STAT_FULL, 1'b1);
            end else begin
                place_sorted(h, dl);
                expect_reply(KIND_STATUS, '0, STAT_OK, 1'b1);
            end
        end else if (pos < 0) begin
            expect_reply(KIND_STATUS, '0, STAT_NOT_FOUND, 1'b1);
        end else begin
            drop_slot(pos);
            if (m == MODE_ADJUST) place_sorted(h, dl);
            expect_reply(KIND_STATUS, '0, STAT_OK, 1'b1);
        end
    endfunction

    task automatic send_command(input t_mode m, input logic [HB-1:0] h, input logic [31:0] dl,
                                input logic [31:0] now);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.mode     <= m;
        cmd_if.handle   <= h;
        cmd_if.deadline <= dl;
        cmd_if.now_time <= now;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        timer_list_apply(m, h, dl, now);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        send_command(MODE_ADD,    10'd0,    32'd0,          32'd0);
        send_command(MODE_ADD,    10'd1023, 32'hFFFF_FFFF,  32'd0);
        send_command(MODE_ADD,    10'd0,    32'd5,          32'd0);
        send_command(MODE_ADJUST, 10'd77,   32'd10,         32'd0);
        send_command(MODE_DELETE, 10'd77,   32'd0,          32'd0);
        send_command(MODE_TICK,   10'd0,    32'd0,          32'd0);
        send_command(MODE_TICK,   10'd0,    32'd0,          32'd0);
        idle_on = 1'b1;
        send_command(MODE_ADD,    10'd5,    32'd100,        32'd0);
        send_command(MODE_ADD,    10'd6,    32'd100,        32'd0);
        send_command(MODE_ADD,    10'd7,    32'd100,        32'd0);
        send_command(MODE_ADJUST, 10'd5,    32'd100,        32'd0);
        send_command(MODE_ADJUST, 10'd7,    32'd50,         32'd0);
        send_command(MODE_ADD,    10'd8,    32'd100,        32'd0);
        send_command(MODE_DELETE, 10'd6,    32'd0,          32'd0);
        send_command(MODE_TICK,   10'd0,    32'd0,          32'd99);
        send_command(MODE_TICK,   10'd0,    32'd0,          32'd100);
        send_command(MODE_TICK,   10'd0,    32'd0,          32'hFFFF_FFFF);
        send_command(MODE_DELETE, 10'd1023, 32'd0,          32'd0);
        send_command(MODE_ADD,    10'h2AA,  32'hAAAA_AAAA,  32'h5555_5555);
        send_command(MODE_ADD,    10'h155,  32'h5555_5555,  32'hAAAA_AAAA);
        send_command(MODE_TICK,   10'h3FF,  32'hFFFF_FFFF,  32'h5555_5555);
        send_command(MODE_TICK,   10'h000,  32'h0000_0000,  32'hFFFF_FFFF);
    endtask

    task automatic test_full_queue();
        logic [HB-1:0] base;
        idle_on = 1'b1;
        base = 10'($urandom_range(0, 900));
        for (int i = 0; i < DEPTH; i++)
            send_command(MODE_ADD, base + HB'(i), 32'($urandom_range(0, 30)), 32'd0);
        send_command(MODE_ADD,    base + HB'(DEPTH), 32'd7, 32'd0);
        send_command(MODE_ADD,    base,              32'd7, 32'd0);
        send_command(MODE_DELETE, base + 10'd3,      32'd0, 32'd0);
        send_command(MODE_ADD,    base + HB'(DEPTH), 32'd30, 32'd0);
        send_command(MODE_ADJUST, base + 10'd9,      32'd0, 32'd0);
        wait_drained();
        send_command(MODE_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF);
        send_command(MODE_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [HB-1:0] pool[20];
        logic [31:0]   clock_now;
        logic [HB-1:0] h;
        int            roll;
        clock_now = $urandom;
        foreach (pool[i]) pool[i] = 10'($urandom_range(0, 1023));
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
            h    = pool[$urandom_range(0, 19)];
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                send_command(MODE_ADD, h, clock_now + $urandom_range(0, 60), $urandom);
            end else if (roll < 55) begin
                send_command(MODE_ADJUST, h, clock_now + $urandom_range(0, 60), $urandom);
            end else if (roll < 70) begin
                send_command(MODE_DELETE, h, $urandom, $urandom);
            end else if (roll < 95) begin
                clock_now = clock_now + $urandom_range(0, 25);
                send_command(MODE_TICK, 10'($urandom), $urandom, clock_now);
            end else begin
                send_command(t_mode'($urandom_range(0, 3)), 10'($urandom), $urandom, $urandom);
            end
            if (i == n_items / 2) wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) sink_wait = draw_gap();
            if (sink_wait > 0) begin
                res_if.ready <= 1'b0;
                sink_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_timer_reply exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result item: kind %0d handle %0d status %0d last %0d",
                       res_if.kind, res_if.expired_handle, res_if.status, res_if.last);
                fail_count++;
            end else begin
                exp_r = replies_due.pop_front();
                if (res_if.kind !== exp_r.kind) begin
                    $error("kind: expected %0d, actual %0d", exp_r.kind, res_if.kind);
                    fail_count++;
                end
                if (res_if.expired_handle !== exp_r.handle) begin
                    $error("expired_handle: expected %0d, actual %0d",
                           exp_r.handle, res_if.expired_handle);
                    fail_count++;
                end
                if (res_if.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, res_if.status);
                    fail_count++;
                end
                if (res_if.last !== exp_r.last) begin
                    $error("last: expected %0d, actual %0d", exp_r.last, res_if.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        fail_count      = 0;
        idle_cycles     = 0;
        sink_wait       = 0;
        idle_on         = 1'b0;
        tq_count        = 0;
        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.mode     <= MODE_ADD;
        cmd_if.handle   <= '0;
        cmd_if.deadline <= '0;
        cmd_if.now_time <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_queue();
        test_random_traffic(440);
        wait_drained();
        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
